FILE: hw/rtl/nrtbs_pkg.sv
// ----------------------------------------------------------------------------
// NR transport block size: shared package
// Constants, the small-size table, code-block segmentation modes and the
// beat format that travels through the ceiling divider.
// ----------------------------------------------------------------------------
package nrtbs_pkg;

	localparam int SMALL_TABLE_ENTRIES = 93;
	localparam int RE_PER_RB_MAX = 156;
	localparam int SMALL_LIMIT = 3824;
	localparam int LARGE_MIN = 3840;
	localparam int CB_LOW_RATE = 3816;
	localparam int CB_HIGH_RATE = 8424;
	localparam int CRC_BITS = 24;
	localparam int INFO_SAT = 2800000;
	localparam int LOW_RATE_MAX = 256;

	// Quotient width of the final ceiling division (quotient never exceeds 1054).
	localparam int QUO_BITS = 11;

	// Reciprocals used to divide by the two code block limits.
	localparam int RECIP_SHIFT = 32;
	localparam logic [20:0] RECIP_LOW = 21'((64'd1 << RECIP_SHIFT) / 64'(CB_LOW_RATE));
	localparam logic [20:0] RECIP_HIGH = 21'((64'd1 << RECIP_SHIFT) / 64'(CB_HIGH_RATE));

	localparam logic [1:0] SEG_NONE = 2'd0;
	localparam logic [1:0] SEG_LOW = 2'd1;
	localparam logic [1:0] SEG_HIGH = 2'd2;

	localparam logic [11:0] SMALL_SIZES [SMALL_TABLE_ENTRIES] = '{
		12'd24, 12'd32, 12'd40, 12'd48, 12'd56, 12'd64, 12'd72, 12'd80, 12'd88, 12'd96,
		12'd104, 12'd112, 12'd120, 12'd128, 12'd136, 12'd144, 12'd152, 12'd160, 12'd168,
		12'd176, 12'd184, 12'd192, 12'd208, 12'd224, 12'd240, 12'd256, 12'd272, 12'd288,
		12'd304, 12'd320, 12'd336, 12'd352, 12'd368, 12'd384, 12'd408, 12'd432, 12'd456,
		12'd480, 12'd504, 12'd528, 12'd552, 12'd576, 12'd608, 12'd640, 12'd672, 12'd704,
		12'd736, 12'd768, 12'd808, 12'd848, 12'd888, 12'd928, 12'd984, 12'd1032, 12'd1064,
		12'd1128, 12'd1160, 12'd1192, 12'd1224, 12'd1256, 12'd1288, 12'd1320, 12'd1352,
		12'd1416, 12'd1480, 12'd1544, 12'd1608, 12'd1672, 12'd1736, 12'd1800, 12'd1864,
		12'd1928, 12'd2024, 12'd2088, 12'd2152, 12'd2216, 12'd2280, 12'd2408, 12'd2472,
		12'd2536, 12'd2600, 12'd2664, 12'd2728, 12'd2792, 12'd2856, 12'd2976, 12'd3104,
		12'd3240, 12'd3368, 12'd3496, 12'd3624, 12'd3752, 12'd3824
	};

	typedef struct packed {
		logic [21:0] info;
		logic is_small;
		logic [11:0] small_tbs;
		logic [23:0] rem;
		logic [14:0] unit;
		logic [QUO_BITS-1:0] quo;
	} div_t;

	// Position of the highest set bit; zero for a zero input.
	function automatic logic [4:0] flog2(input logic [21:0] x);
		logic [4:0] r;
		r = '0;
		for (int i = 0; i < 22; i++) begin
			if (x[i]) r = 5'(i);
		end
		return r;
	endfunction

	// Smallest table entry not below q, the last entry if none.
	function automatic logic [11:0] small_lookup(input logic [11:0] q);
		logic [11:0] r;
		r = SMALL_SIZES[SMALL_TABLE_ENTRIES-1];
		for (int i = SMALL_TABLE_ENTRIES - 1; i >= 0; i--) begin
			if (SMALL_SIZES[i] >= q) r = SMALL_SIZES[i];
		end
		return r;
	endfunction

endpackage

FILE: hw/rtl/nrtbs_ifs.sv
// ----------------------------------------------------------------------------
// NR transport block size: channel interfaces
// Grant input, result output and configuration write channels.
// ----------------------------------------------------------------------------
interface nrtbs_grant_if;
	logic valid;
	logic ready;
	logic [3:0] qm;
	logic [9:0] rate_x1024;
	logic [8:0] prb_count;
	logic [3:0] symbol_count;
	logic [7:0] dmrs_re;
	logic [3:0] layers;
	modport source(output valid, qm, rate_x1024, prb_count, symbol_count, dmrs_re, layers,
		input ready);
	modport sink(input valid, qm, rate_x1024, prb_count, symbol_count, dmrs_re, layers,
		output ready);
endinterface

interface nrtbs_result_if;
	logic valid;
	logic ready;
	logic [21:0] info_bits;
	logic [21:0] tbs_bits;
	modport source(output valid, info_bits, tbs_bits, input ready);
	modport sink(input valid, info_bits, tbs_bits, output ready);
endinterface

interface nrtbs_cfg_if;
	logic valid;
	logic ready;
	logic [4:0] overhead_re;
	modport source(output valid, overhead_re, input ready);
	modport sink(input valid, overhead_re, output ready);
endinterface

FILE: hw/rtl/nrtbs_div.sv
// ----------------------------------------------------------------------------
// NR transport block size: pipelined ceiling divider
// Restoring division, one quotient bit per stage, rem / unit into quo.
// ----------------------------------------------------------------------------
module nrtbs_div import nrtbs_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic in_valid,
	input div_t in_data,
	output logic out_valid,
	output div_t out_data
);

	logic vld_s [QUO_BITS+1];
	div_t dv_s [QUO_BITS+1];

	assign vld_s[0] = in_valid;
	assign dv_s[0] = in_data;

	for (genvar k = 0; k < QUO_BITS; k++) begin : g_stage
		localparam int BIT = QUO_BITS - 1 - k;
		div_t nxt;
		logic [25:0] trial;

		always_comb begin
			nxt = dv_s[k];
			trial = 26'(dv_s[k].unit) << BIT;
			if ({2'b00, dv_s[k].rem} >= trial) begin
				nxt.rem = dv_s[k].rem - trial[23:0];
				nxt.quo[BIT] = 1'b1;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dv_s[k+1] <= nxt;
			end
		end
	end

	assign out_valid = vld_s[QUO_BITS];
	assign out_data = dv_s[QUO_BITS];

endmodule

FILE: hw/rtl/nr_transport_block_size.sv
// ----------------------------------------------------------------------------
// NR transport block size
// Computes N_info and the transport block size for one downlink grant a beat.
// ----------------------------------------------------------------------------
// The block takes one grant beat per clock while the output is not stalled
// and returns one result beat per grant, in order. The pipeline is nine
// arithmetic stages (resource element count and three multiplier stages for
// N_info, saturation, quantization, table lookup, code block estimate and
// correction, and divider setup) plus an eleven stage restoring divider that
// forms the final ceiling, and one output register. All stages advance
// together whenever the output register is empty or being drained, so a
// stalled result holds the whole pipeline and nothing is lost or repeated.
// The overhead register is written through the configuration channel, which
// is always ready; write it only while no grant is in flight.
module nr_transport_block_size import nrtbs_pkg::*; (
	input logic clk,
	input logic arst_n,
	nrtbs_grant_if.sink grant,
	nrtbs_result_if.source result,
	nrtbs_cfg_if.sink cfg
);

	logic [4:0] overhead_q;
	logic en;
	logic out_valid_q;
	logic [21:0] info_out_q;
	logic [21:0] tbs_out_q;

	// Whole pipeline moves when the output register can take a new beat.
	assign en = !out_valid_q || result.ready;
	assign grant.ready = en;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			overhead_q <= '0;
		end else if (cfg.valid) begin
			overhead_q <= cfg.overhead_re;
		end
	end

	// Stage 1: per-RB element count, clamped, and the first two products.
	logic [7:0] gross;
	logic [8:0] minus;
	logic [8:0] diff;
	logic [7:0] per_rb;
	logic v_s1;
	logic [7:0] per_rb_s1;
	logic [18:0] a_s1;
	logic [7:0] ql_s1;
	logic low_rate_s1;

	always_comb begin
		gross = 8'(grant.symbol_count * 8'd12);
		minus = {1'b0, grant.dmrs_re} + {4'b0, overhead_q};
		diff = {1'b0, gross} - minus;
		if ({1'b0, gross} <= minus) begin
			per_rb = '0;
		end else if (diff > 9'(RE_PER_RB_MAX)) begin
			per_rb = 8'(RE_PER_RB_MAX);
		end else begin
			per_rb = diff[7:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= grant.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			per_rb_s1 <= per_rb;
			a_s1 <= 19'(grant.prb_count) * 19'(grant.rate_x1024);
			ql_s1 <= 8'(grant.qm) * 8'(grant.layers);
			low_rate_s1 <= grant.rate_x1024 <= 10'(LOW_RATE_MAX);
		end
	end

	// Stage 2: elements times modulation order times layers.
	logic v_s2;
	logic [18:0] a_s2;
	logic [15:0] c_s2;
	logic low_rate_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s2 <= a_s1;
			c_s2 <= 16'(per_rb_s1) * 16'(ql_s1);
			low_rate_s2 <= low_rate_s1;
		end
	end

	// Stage 3: full product, divided by 1024.
	logic [34:0] prod;
	logic v_s3;
	logic [24:0] prod_s3;
	logic low_rate_s3;

	assign prod = 35'(a_s2) * 35'(c_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s3 <= prod[34:10];
			low_rate_s3 <= low_rate_s2;
		end
	end

	// Stage 4: saturation and the small/large split.
	logic [21:0] info_sat;
	logic v_s4;
	logic [21:0] info_s4;
	logic [21:0] base_s4;
	logic small_s4;
	logic low_rate_s4;

	assign info_sat = (prod_s3 > 25'(INFO_SAT)) ? 22'(INFO_SAT) : prod_s3[21:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			info_s4 <= info_sat;
			base_s4 <= info_sat - 22'(CRC_BITS);
			small_s4 <= info_sat <= 22'(SMALL_LIMIT);
			low_rate_s4 <= low_rate_s3;
		end
	end

	// Stage 5: quantization shift from the leading one.
	logic [4:0] lg_info;
	logic [4:0] lg_base;
	logic [4:0] shift;
	logic v_s5;
	logic [21:0] info_s5;
	logic [21:0] base_s5;
	logic small_s5;
	logic low_rate_s5;
	logic [4:0] shift_s5;

	always_comb begin
		lg_info = flog2(info_s4);
		lg_base = flog2(base_s4);
		if (small_s4) begin
			shift = (info_s4 != '0 && lg_info > 5'd9) ? lg_info - 5'd6 : 5'd3;
		end else begin
			shift = lg_base - 5'd5;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			info_s5 <= info_s4;
			base_s5 <= base_s4;
			small_s5 <= small_s4;
			low_rate_s5 <= low_rate_s4;
			shift_s5 <= shift;
		end
	end

	// Stage 6: quantized sizes, small table lookup and segmentation mode.
	logic [21:0] q_small;
	logic [22:0] q_round;
	logic [22:0] q_large;
	logic [1:0] mode;
	logic v_s6;
	logic [21:0] info_s6;
	logic small_s6;
	logic [11:0] small_tbs_s6;
	logic [22:0] total_s6;
	logic [1:0] mode_s6;

	always_comb begin
		q_small = (info_s5 >> shift_s5) << shift_s5;
		if (q_small < 22'(CRC_BITS)) q_small = 22'(CRC_BITS);
		q_round = 23'(base_s5) + (23'd1 << (shift_s5 - 5'd1));
		q_large = (q_round >> shift_s5) << shift_s5;
		if (q_large < 23'(LARGE_MIN)) q_large = 23'(LARGE_MIN);
		if (low_rate_s5) begin
			mode = SEG_LOW;
		end else if (q_large > 23'(CB_HIGH_RATE)) begin
			mode = SEG_HIGH;
		end else begin
			mode = SEG_NONE;
		end
		if (small_s5) mode = SEG_NONE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			info_s6 <= info_s5;
			small_s6 <= small_s5;
			small_tbs_s6 <= small_lookup(q_small[11:0]);
			total_s6 <= q_large + 23'(CRC_BITS);
			mode_s6 <= mode;
		end
	end

	// Stage 7: code block count estimate by reciprocal multiplication.
	logic [13:0] cb;
	logic [20:0] recip;
	logic [23:0] y;
	logic [44:0] est;
	logic v_s7;
	logic [21:0] info_s7;
	logic small_s7;
	logic [11:0] small_tbs_s7;
	logic [22:0] total_s7;
	logic [1:0] mode_s7;
	logic [23:0] y_s7;
	logic [11:0] q0_s7;

	always_comb begin
		case (mode_s6)
			SEG_HIGH: begin
				cb = 14'(CB_HIGH_RATE);
				recip = RECIP_HIGH;
			end
			default: begin
				cb = 14'(CB_LOW_RATE);
				recip = RECIP_LOW;
			end
		endcase
		y = 24'(total_s6) + 24'(cb) - 24'd1;
		est = 45'(y) * 45'(recip);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			info_s7 <= info_s6;
			small_s7 <= small_s6;
			small_tbs_s7 <= small_tbs_s6;
			total_s7 <= total_s6;
			mode_s7 <= mode_s6;
			y_s7 <= y;
			q0_s7 <= est[RECIP_SHIFT+11:RECIP_SHIFT];
		end
	end

	// Stage 8: the estimate is at most one low; correct it, or use one code block when not segmenting.
	logic [13:0] cb7;
	logic [25:0] rem0;
	logic [11:0] cbs;
	logic v_s8;
	logic [21:0] info_s8;
	logic small_s8;
	logic [11:0] small_tbs_s8;
	logic [22:0] total_s8;
	logic [11:0] cbs_s8;

	always_comb begin
		cb7 = (mode_s7 == SEG_HIGH) ? 14'(CB_HIGH_RATE) : 14'(CB_LOW_RATE);
		rem0 = 26'(y_s7) - 26'(q0_s7) * 26'(cb7);
		cbs = (rem0 >= 26'(cb7)) ? q0_s7 + 12'd1 : q0_s7;
		if (mode_s7 == SEG_NONE) cbs = 12'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8 <= 1'b0;
		end else if (en) begin
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			info_s8 <= info_s7;
			small_s8 <= small_s7;
			small_tbs_s8 <= small_tbs_s7;
			total_s8 <= total_s7;
			cbs_s8 <= cbs;
		end
	end

	// Stage 9: divisor 8*C and rounded-up numerator for the divider.
	logic [14:0] unit;
	logic v_s9;
	div_t dv_s9;

	assign unit = {cbs_s8, 3'b000};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s9 <= 1'b0;
		end else if (en) begin
			v_s9 <= v_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dv_s9.info <= info_s8;
			dv_s9.is_small <= small_s8;
			dv_s9.small_tbs <= small_tbs_s8;
			dv_s9.unit <= unit;
			dv_s9.rem <= 24'(total_s8) + 24'(unit) - 24'd1;
			dv_s9.quo <= '0;
		end
	end

	logic dv_valid;
	div_t dv_out;

	nrtbs_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_valid(v_s9),
		.in_data(dv_s9),
		.out_valid(dv_valid),
		.out_data(dv_out)
	);

	// Output register: the small table size, or else 8*C times the ceiling, less the CRC length.
	logic [25:0] seg_size;

	assign seg_size = 26'(dv_out.unit) * 26'(dv_out.quo) - 26'(CRC_BITS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= dv_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			info_out_q <= dv_out.info;
			tbs_out_q <= dv_out.is_small ? 22'(dv_out.small_tbs) : seg_size[21:0];
		end
	end

	assign result.valid = out_valid_q;
	assign result.info_bits = info_out_q;
	assign result.tbs_bits = tbs_out_q;

endmodule
